/* rtl/core/nbu5_pkg.sv */
package nbu5_pkg;

	// SHA-1 initial chain value, H0 in element 0
	localparam logic [4:0][31:0] SHA_INIT = '{
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	// round constants, one per group of twenty rounds
	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam int unsigned ROUNDS = 80;

	// padding and UUID stamping
	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam logic [7:0] PAD_ZERO     = 8'h00;
	localparam logic [7:0] VER_KEEP     = 8'h0F;
	localparam logic [7:0] VER_FIVE     = 8'h50;
	localparam logic [7:0] VAR_KEEP     = 8'hBF;
	localparam logic [7:0] VAR_RFC      = 8'h80;
	localparam logic [5:0] LEN_POS      = 6'd55;
	localparam logic [5:0] BLOCK_END    = 6'd63;

	typedef logic [4:0][31:0] chain_t;

	// byte feed into the hash engine
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} byte_feed_t;

	// engine status back to the sequencer
	typedef struct packed {
		logic       busy;
		logic [5:0] fill;
	} eng_stat_t;

endpackage

/* rtl/core/nbu5_sha1.sv */
module nbu5_sha1 (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nbu5_pkg::byte_feed_t feed,
	input  logic                 restart,
	output nbu5_pkg::eng_stat_t  stat,
	output nbu5_pkg::chain_t     chain
);

	localparam logic [1:0] E_LOAD  = 2'd0;
	localparam logic [1:0] E_ROUND = 2'd1;
	localparam logic [1:0] E_ADD   = 2'd2;

	logic [1:0]             est_q;
	logic [5:0]             fill_q;
	logic [6:0]             rnd_q;
	logic [511:0]           blk_q;
	nbu5_pkg::chain_t       vars_q;
	nbu5_pkg::chain_t       chain_q;
	logic                   take;
	logic [31:0]            w0, w2, w8, w13, wmix, wnew;
	logic [31:0]            fa, fb, fc, fd, fe, f, k, tmp;

	assign take  = feed.valid && (est_q == E_LOAD);
	assign stat  = '{busy: (est_q != E_LOAD), fill: fill_q};
	assign chain = chain_q;

	// schedule taps on the sliding window, word 0 is the current round's word
	assign w0   = blk_q[511:480];
	assign w2   = blk_q[447:416];
	assign w8   = blk_q[255:224];
	assign w13  = blk_q[95:64];
	assign wmix = w13 ^ w8 ^ w2 ^ w0;
	assign wnew = {wmix[30:0], wmix[31]};

	// round function of the shared unit
	always_comb begin
		fa = vars_q[0];
		fb = vars_q[1];
		fc = vars_q[2];
		fd = vars_q[3];
		fe = vars_q[4];
		if (rnd_q < 7'd20) begin
			f = (fb & fc) | (~fb & fd);
			k = nbu5_pkg::K_R0;
		end else if (rnd_q < 7'd40) begin
			f = fb ^ fc ^ fd;
			k = nbu5_pkg::K_R1;
		end else if (rnd_q < 7'd60) begin
			f = (fb & fc) | (fb & fd) | (fc & fd);
			k = nbu5_pkg::K_R2;
		end else begin
			f = fb ^ fc ^ fd;
			k = nbu5_pkg::K_R3;
		end
		tmp = {fa[26:0], fa[31:27]} + f + fe + k + w0;
	end

	// sequencer: collect bytes, run eighty rounds, fold into the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q   <= E_LOAD;
			fill_q  <= '0;
			rnd_q   <= '0;
			chain_q <= nbu5_pkg::SHA_INIT;
		end else begin
			case (est_q)
				E_LOAD: begin
					if (restart) begin
						chain_q <= nbu5_pkg::SHA_INIT;
					end
					if (take) begin
						fill_q <= fill_q + 6'd1;
						if (fill_q == nbu5_pkg::BLOCK_END) begin
							est_q <= E_ROUND;
							rnd_q <= '0;
						end
					end
				end
				E_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(nbu5_pkg::ROUNDS - 1)) begin
						est_q <= E_ADD;
					end
				end
				E_ADD: begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= chain_q[i] + vars_q[i];
					end
					est_q <= E_LOAD;
				end
				default: est_q <= E_LOAD;
			endcase
		end
	end

	// block window and working variables
	always_ff @(posedge clk) begin
		if (take) begin
			blk_q <= {blk_q[503:0], feed.data};
			if (fill_q == nbu5_pkg::BLOCK_END) begin
				vars_q <= chain_q;
			end
		end else if (est_q == E_ROUND) begin
			blk_q     <= {blk_q[479:0], wnew};
			vars_q[4] <= vars_q[3];
			vars_q[3] <= vars_q[2];
			vars_q[2] <= {vars_q[1][1:0], vars_q[1][31:2]};
			vars_q[1] <= vars_q[0];
			vars_q[0] <= tmp;
		end
	end

endmodule

/* rtl/core/name_based_uuid_v5_sha1.sv */
// Version 5 UUID over a byte stream, hashed with SHA-1 one round per cycle.
// Bytes are taken one per cycle while the engine is idle; every full 64-byte block then
// runs 80 rounds through the shared round unit plus the chain fold, stalling the input.
// Closing item: padding and length go in one byte a cycle while the engine is free (up
// to 72 bytes, one or two compressions), then the result loads the output register.
// Async active-low reset sets the chain to the SHA-1 constants and mode to 0.
module name_based_uuid_v5_sha1 (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] has_byte
	input  logic         s_tlast,   // last_item
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] uuid_high, [127:64] uuid_low
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]           st_q;
	logic                 pad_first_q;
	logic [2:0]           len_cnt_q;
	logic [63:0]          len_q;
	logic                 host_be_q;
	logic                 out_valid_q;
	logic [127:0]         out_data_q;
	logic                 restart;
	logic                 out_load;
	logic                 in_take;
	nbu5_pkg::byte_feed_t feed;
	nbu5_pkg::eng_stat_t  eng;
	nbu5_pkg::chain_t     chain;
	logic [127:0]         dg;
	logic [7:0]           d [16];
	logic [7:0]           ver_byte;
	logic [63:0]          uuid_high;
	logic [63:0]          uuid_low;

	nbu5_sha1 u_sha1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.feed    (feed),
		.restart (restart),
		.stat    (eng),
		.chain   (chain)
	);

	assign s_tready  = (st_q == ST_IDLE) && !eng.busy;
	assign in_take   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign out_load = (st_q == ST_DONE) && !eng.busy && (!out_valid_q || m_tready);
	assign restart  = out_load;

	// pick the byte for the engine: message, padding or length
	always_comb begin
		feed = '{valid: 1'b0, data: nbu5_pkg::PAD_ZERO};
		case (st_q)
			ST_IDLE: feed = '{valid: in_take && s_tuser, data: s_tdata};
			ST_PAD:  feed = '{valid: !eng.busy,
				data: pad_first_q ? nbu5_pkg::PAD_MARK : nbu5_pkg::PAD_ZERO};
			ST_LEN:  feed = '{valid: !eng.busy, data: len_q[63:56]};
			default: feed = '{valid: 1'b0, data: nbu5_pkg::PAD_ZERO};
		endcase
	end

	// digest bytes and UUID stamping
	assign dg = {chain[0], chain[1], chain[2], chain[3]};
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			d[i] = dg[127 - 8 * i -: 8];
		end
		ver_byte = (d[6] & nbu5_pkg::VER_KEEP) | nbu5_pkg::VER_FIVE;
		if (host_be_q) begin
			uuid_high = {d[0], d[1], d[2], d[3], d[4], d[5], ver_byte, d[7]};
		end else begin
			uuid_high = {d[3], d[2], d[1], d[0], d[5], d[4], d[7], ver_byte};
		end
		uuid_low = {(d[8] & nbu5_pkg::VAR_KEEP) | nbu5_pkg::VAR_RFC,
			d[9], d[10], d[11], d[12], d[13], d[14], d[15]};
	end

	// message sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pad_first_q <= 1'b0;
			len_cnt_q   <= '0;
			len_q       <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_take) begin
						if (s_tuser) begin
							len_q <= len_q + 64'd8;
						end
						if (s_tlast) begin
							st_q        <= ST_PAD;
							pad_first_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					if (!eng.busy) begin
						pad_first_q <= 1'b0;
						if (eng.fill == nbu5_pkg::LEN_POS) begin
							st_q      <= ST_LEN;
							len_cnt_q <= '0;
						end
					end
				end
				ST_LEN: begin
					if (!eng.busy) begin
						len_q     <= {len_q[55:0], 8'h00};
						len_cnt_q <= len_cnt_q + 3'd1;
						if (len_cnt_q == 3'd7) begin
							st_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// mode register and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_be_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				host_be_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {uuid_low, uuid_high};
		end
	end

`ifndef SYNTH
	a_block_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(feed.valid && !eng.busy && eng.fill == nbu5_pkg::BLOCK_END) |=> eng.busy)
		else $error("full block did not start compression");

	a_len_position: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LEN) |-> (eng.fill[5:3] == 3'b111))
		else $error("length bytes outside the last eight block positions");

	a_done_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && !eng.busy) |-> (eng.fill == 6'd0))
		else $error("padded message not block aligned");

	a_len_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE) |-> (len_q == 64'd0))
		else $error("length not fully shifted out");
`endif

endmodule

/* tb/uuid_stream_checker.sv */
module uuid_stream_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] has_byte
	input  logic         s_tlast,   // last_item
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,   // [63:0] uuid_high, [127:64] uuid_low
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic         cfg_data,
	output int           fail_count,
	output int           uuids_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [31:0] ROUND_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};
	localparam logic [7:0] PAD_START    = 8'h80;
	localparam logic [7:0] ZERO_FILL    = 8'h00;
	localparam logic [7:0] VERSION_KEEP = 8'h0F;
	localparam logic [7:0] VERSION_FIVE = 8'h50;
	localparam logic [7:0] VARIANT_KEEP = 8'hBF;
	localparam logic [7:0] VARIANT_RFC  = 8'h80;
	localparam logic [5:0] LEN_FIELD_AT = 6'd56;
	localparam logic [5:0] BLOCK_LAST   = 6'd63;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} uuid_words_t;

	logic [31:0] chain [5];
	logic [7:0]  block_bytes [64];
	logic [63:0] msg_bits;
	logic        digest_order;
	uuid_words_t uuid_queue [$];
	int          errs;

	// store one byte in the block; run the 80 rounds once the block is full
	function automatic void place_byte(input logic [5:0] at, input logic [7:0] value);
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, wt, sum;
		block_bytes[at] = value;
		if (at == BLOCK_LAST) begin
			for (int i = 0; i < 16; i++) begin
				w[i] = {block_bytes[4*i], block_bytes[4*i+1],
					block_bytes[4*i+2], block_bytes[4*i+3]};
			end
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int t = 0; t < 80; t++) begin
				if (t < 16) begin
					wt = w[t];
				end else begin
					wt = w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16];
					wt = {wt[30:0], wt[31]};
					w[t%16] = wt;
				end
				if (t < 20) begin
					f = (b & c) | (~b & d);
				end else if (t < 40 || t >= 60) begin
					f = b ^ c ^ d;
				end else begin
					f = (b & c) | (b & d) | (c & d);
				end
				k = ROUND_K[t / 20];
				sum = {a[26:0], a[31:27]} + f + e + k + wt;
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = sum;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		end
	endfunction

	// return the hash to the start of a fresh message
	function automatic void restart_message();
		for (int i = 0; i < 5; i++) begin
			chain[i] = SHA1_IV[i];
		end
		msg_bits = '0;
	endfunction

	// track config and input items, predict each UUID, match output items in order
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] bit_len;
		logic [5:0]  at;
		logic [7:0]  dg [16];
		logic [7:0]  rb [16];
		uuid_words_t want;
		uuid_words_t got;
		if (!arst_n) begin
			digest_order = 1'b0;
			for (int i = 0; i < 64; i++) begin
				block_bytes[i] = ZERO_FILL;
			end
			restart_message();
			uuid_queue.delete();
			errs = 0;
			fail_count <= 0;
			uuids_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				digest_order = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					place_byte(msg_bits[8:3], s_tdata);
					msg_bits += 64'd8;
				end
				if (s_tlast) begin
					// pad: marker, zero fill, then the 64-bit bit count
					bit_len = msg_bits;
					at = bit_len[8:3];
					place_byte(at, PAD_START);
					at = at + 6'd1;
					while (at != LEN_FIELD_AT) begin
						place_byte(at, ZERO_FILL);
						at = at + 6'd1;
					end
					for (int i = 0; i < 8; i++) begin
						place_byte(LEN_FIELD_AT + 6'(i), bit_len[63 - 8*i -: 8]);
					end
					for (int i = 0; i < 16; i++) begin
						dg[i] = chain[i/4][31 - 8*(i%4) -: 8];
					end
					// stamp version and variant, swap the leading fields in host mode
					rb = dg;
					if (digest_order) begin
						rb[6] = (dg[6] & VERSION_KEEP) | VERSION_FIVE;
						rb[7] = dg[7];
					end else begin
						rb[0] = dg[3];
						rb[1] = dg[2];
						rb[2] = dg[1];
						rb[3] = dg[0];
						rb[4] = dg[5];
						rb[5] = dg[4];
						rb[6] = dg[7];
						rb[7] = (dg[6] & VERSION_KEEP) | VERSION_FIVE;
					end
					rb[8] = (dg[8] & VARIANT_KEEP) | VARIANT_RFC;
					want = '0;
					for (int i = 0; i < 8; i++) begin
						want.hi = {want.hi[55:0], rb[i]};
						want.lo = {want.lo[55:0], rb[8+i]};
					end
					uuid_queue.push_back(want);
					restart_message();
				end
			end
			if (m_tvalid && m_tready) begin
				got.hi = m_tdata[63:0];
				got.lo = m_tdata[127:64];
				if (uuid_queue.size() == 0) begin
					$display("%0t unexpected uuid: expected none, got %h %h",
						$time, got.hi, got.lo);
					errs++;
				end else begin
					want = uuid_queue.pop_front();
					if (got.hi !== want.hi) begin
						$display("%0t uuid_high mismatch: expected %h, got %h",
							$time, want.hi, got.hi);
						errs++;
					end
					if (got.lo !== want.lo) begin
						$display("%0t uuid_low mismatch: expected %h, got %h",
							$time, want.lo, got.lo);
						errs++;
					end
				end
			end
			fail_count <= errs;
			uuids_due <= uuid_queue.size();
		end
	end

endmodule

/* tb/tb_name_based_uuid_v5_sha1.sv */
module tb_name_based_uuid_v5_sha1;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit MODE_HOST_SWAP    = 1'b0;
	localparam bit MODE_DIGEST_ORDER = 1'b1;
	localparam int HOLD_CYCLES   = 600;
	localparam int DRAIN_CYCLES  = 300;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int ITEM_GOAL     = 900;
	localparam int RANDOM_PHASES = 6;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_DENSE} rx_style_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic [7:0]   s_tdata   = 8'h00;
	logic         s_tuser   = 1'b0;
	logic         s_tlast   = 1'b0;
	logic         m_tready  = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_data  = 1'b0;
	logic         s_tready;
	logic         m_tvalid;
	logic [127:0] m_tdata;
	logic         cfg_ready;

	int        fails;
	int        uuids_due;
	int        burst_left  = 0;
	bit        calm        = 1'b0;
	int        items_done  = 0;
	int        hold_asks   = 0;
	int        hold_served = 0;
	int        hold_left   = 0;
	rx_style_t rx_style    = RX_OPEN;
	int        rx_span     = 0;
	int        cycle_count = 0;

	// message lengths around the padding and block boundaries
	int unsigned pad_edges [13] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	name_based_uuid_v5_sha1 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	uuid_stream_checker uuid_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fails),
		.uuids_due  (uuids_due)
	);

	always #6 clk = ~clk;

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_served != hold_asks) begin
			hold_served <= hold_asks;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (rx_span == 0) begin
				rx_style <= rx_style_t'($urandom_range(0, 3));
				rx_span <= $urandom_range(16, 96);
			end else begin
				rx_span <= rx_span - 1;
			end
			case (rx_style)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// offer one item, with a random gap (none when calm) whenever a burst runs out
	task automatic send_item(input logic [7:0] value, input logic has, input logic last);
		int gap;
		if (burst_left <= 0) begin
			if (calm) begin
				gap = 0;
			end else if ($urandom_range(0, 7) == 0) begin
				gap = $urandom_range(4, 12);
			end else begin
				gap = $urandom_range(0, 3);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= has;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (has || last) begin
			items_done++;
		end
	endtask

	// one message of random bytes, sometimes closed by an empty item, with stray empty items
	task automatic send_message(input int len);
		bit close_empty;
		close_empty = (len == 0) || ($urandom_range(0, 4) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0);
			end
			send_item(8'($urandom), 1'b1, !close_empty && i == len - 1);
		end
		if (close_empty) begin
			send_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic set_mode(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, wait for every predicted UUID, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (uuids_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int msg_len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed messages in both byte orders
		for (int m = 0; m < 2; m++) begin
			set_mode(m == 0 ? MODE_HOST_SWAP : MODE_DIGEST_ORDER);
			send_item(8'h00, 1'b0, 1'b1);
			send_item(8'h00, 1'b1, 1'b1);
			send_item(8'hFF, 1'b1, 1'b1);
			send_item(8'hFF, 1'b0, 1'b0);
			send_item(8'h00, 1'b1, 1'b0);
			send_item(8'hAB, 1'b1, 1'b0);
			send_item(8'h00, 1'b0, 1'b1);
			send_item(8'h61, 1'b1, 1'b0);
			send_item(8'h62, 1'b1, 1'b0);
			send_item(8'h63, 1'b1, 1'b1);
			drain();
		end

		// random phases, alternating the byte order
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_mode(ph[0] ? MODE_DIGEST_ORDER : MODE_HOST_SWAP);
			calm = (ph == 3);
			if (ph == 1) begin
				// hold the receiver off while short messages keep coming
				hold_asks <= hold_asks + 1;
				calm = 1'b1;
				repeat (24) send_message($urandom_range(0, 3));
				calm = 1'b0;
			end
			while (items_done < (ph + 1) * ITEM_GOAL / RANDOM_PHASES + 20) begin
				case ($urandom_range(0, 15))
					0, 1, 2: msg_len = pad_edges[$urandom_range(0, 12)];
					3:       msg_len = $urandom_range(65, 160);
					default: msg_len = $urandom_range(0, 12);
				endcase
				send_message(msg_len);
			end
			drain();
		end

		if (fails == 0) begin
			$display("name_based_uuid_v5_sha1 verification clean");
		end else begin
			$display("name_based_uuid_v5_sha1 verification failed");
		end
		$finish;
	end

	// end a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("name_based_uuid_v5_sha1 verification failed");
		$finish;
	end

endmodule

/* name_based_uuid_v5_sha1.f */
rtl/core/nbu5_pkg.sv
rtl/core/nbu5_sha1.sv
rtl/core/name_based_uuid_v5_sha1.sv
tb/uuid_stream_checker.sv
tb/tb_name_based_uuid_v5_sha1.sv
